// ===== hdl/rpff_pkg.sv =====
// Shared constants, codes and pipeline stage types of the relative permeability unit.
package rpff_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SAT_W = FRAC_BITS + 1;
	localparam int PERM_W = FRAC_BITS + 2;
	localparam int MOB_W = FRAC_BITS + 8;
	localparam int CDIV_STEPS = FRAC_BITS + 1;
	localparam int MDIV_STEPS = PERM_W + 8;
	localparam int FDIV_STEPS = FRAC_BITS + 1;

	localparam logic [SAT_W-1:0] ONE = SAT_W'(1) << FRAC_BITS;
	localparam logic [PERM_W-1:0] PERM_MAX = '1;
	localparam logic [MOB_W-1:0] MOB_MAX = '1;
	localparam logic [2*SAT_W:0] HALF = (2*SAT_W+1)'(1) << (FRAC_BITS - 1);

	typedef enum logic [1:0] {
		MODEL_INVALID = 2'd0,
		MODEL_LINEAR = 2'd1,
		MODEL_QUADRATIC = 2'd2,
		MODEL_COREY = 2'd3
	} perm_model_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_UNKNOWN_MODEL = 2'd1,
		ST_ZERO_DEN = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_IRR_WATER = 3'd0,
		REG_RES_OIL = 3'd1,
		REG_WATER_VISC = 3'd2,
		REG_OIL_VISC = 3'd3,
		REG_PERM_MODEL = 3'd4
	} reg_index_t;

	// Corey normalization divider lane pair.
	typedef struct packed {
		logic vld;
		logic [SAT_W-1:0] s;
		logic [SAT_W-1:0] rw;
		logic [SAT_W-1:0] ro;
		logic [SAT_W-1:0] qw;
		logic [SAT_W-1:0] qo;
		logic bw;
		logic bo;
	} cdiv_t;

	typedef struct packed {
		logic vld;
		logic bw;
		logic bo;
		logic [2*SAT_W-1:0] pw;
		logic [2*SAT_W-1:0] po;
		logic [2*SAT_W-1:0] ps;
		logic [2*SAT_W-1:0] pr;
	} sq_t;

	typedef struct packed {
		logic vld;
		logic sat;
		logic bad;
		logic [PERM_W-1:0] krw;
		logic [PERM_W-1:0] kro;
		logic [PERM_W-1:0] cw;
		logic [PERM_W-1:0] co;
	} kr_t;

	typedef struct packed {
		logic vld;
		logic sat;
		logic bad;
		logic [PERM_W-1:0] krw;
		logic [PERM_W-1:0] kro;
		logic [PERM_W+15:0] fnum;
		logic [PERM_W+15:0] fco;
	} prod_t;

	typedef struct packed {
		logic vld;
		logic sat;
		logic bad;
		logic [PERM_W-1:0] krw;
		logic [PERM_W-1:0] kro;
		logic [PERM_W+16:0] den;
		logic [PERM_W+32:0] nn;
	} fsum_t;

	// Mobility and fractional flow divider stage.
	typedef struct packed {
		logic vld;
		logic sat;
		logic bad;
		logic fzero;
		logic [PERM_W-1:0] krw;
		logic [PERM_W-1:0] kro;
		logic [15:0] mw_rem;
		logic [MDIV_STEPS-1:0] mw_dv;
		logic [MDIV_STEPS-1:0] mw_q;
		logic [15:0] mo_rem;
		logic [MDIV_STEPS-1:0] mo_dv;
		logic [MDIV_STEPS-1:0] mo_q;
		logic [PERM_W+16:0] fr_rem;
		logic [FDIV_STEPS-1:0] fr_n;
		logic [FDIV_STEPS-1:0] fr_q;
		logic [PERM_W+16:0] fr_den;
	} gdiv_t;

endpackage

// ===== hdl/relperm_fractional_flow_unit.sv =====
// Top level: pipelined relative permeability, total mobility and fractional flow unit.
//
//   channel  direction  handshake                   payload
//   s_*      in         s_tvalid / s_tready         s_tdata: water_saturation
//   m_*      out        m_tvalid / m_tready         m_tdata: five results, m_tuser: status
//   cfg_*    in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One item enters per cycle while the pipeline is not held; results leave in order.
// The bit-per-stage dividers make up most of the pipeline: 17 stages for the Corey
// normalization, then 26 stages for the mobility quotients.
// When the output register holds an item that is not taken, the whole pipeline holds.
// Reset clears all stage valid bits and loads the register defaults; no clearing pass.
// Configuration writes are taken in every cycle (cfg_ready is always high).
module relperm_fractional_flow_unit
	import rpff_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [16:0] water_saturation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [17:0] water_rel_perm, [35:18] oil_rel_perm,
	                               // [59:36] total_mobility, [76:60] water_fraction,
	                               // [93:77] oil_fraction
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [14:0] swr_q;
	logic [14:0] sor_q;
	logic [15:0] muw_q;
	logic [15:0] muo_q;
	perm_model_t model_q;

	logic en;
	logic [SAT_W-1:0] den_c;

	cdiv_t cinit;
	cdiv_t cdv_n [CDIV_STEPS];
	cdiv_t cdv_s2 [CDIV_STEPS];
	sq_t sq_n, sq_s19;
	// The square stage keeps the saturation for the linear model.
	logic [SAT_W-1:0] s_s19;
	kr_t kr_n, kr_s20;
	prod_t pr_n, pr_s21;
	fsum_t fs_n, fs_s22;
	gdiv_t ginit;
	gdiv_t gdv_n [MDIV_STEPS];
	gdiv_t gdv_s23 [MDIV_STEPS];

	logic out_vld_s49;
	logic [95:0] out_data_s49;
	status_t out_st_s49;
	logic [95:0] out_data_n;
	status_t out_st_n;

	function automatic cdiv_t cstep(cdiv_t c, logic [SAT_W-1:0] d, logic lw, logic lo);
		cdiv_t r;
		logic [SAT_W:0] tw;
		logic [SAT_W:0] to;
		r = c;
		tw = {c.rw, lw};
		to = {c.ro, lo};
		if (tw >= {1'b0, d}) begin
			r.rw = SAT_W'(tw - {1'b0, d});
			r.qw = {c.qw[SAT_W-2:0], 1'b1};
		end else begin
			r.rw = tw[SAT_W-1:0];
			r.qw = {c.qw[SAT_W-2:0], 1'b0};
		end
		if (to >= {1'b0, d}) begin
			r.ro = SAT_W'(to - {1'b0, d});
			r.qo = {c.qo[SAT_W-2:0], 1'b1};
		end else begin
			r.ro = to[SAT_W-1:0];
			r.qo = {c.qo[SAT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic gdiv_t gstep(gdiv_t g, logic [15:0] muw, logic [15:0] muo, logic frac);
		gdiv_t r;
		logic [16:0] tw;
		logic [16:0] to;
		logic [PERM_W+17:0] tf;
		r = g;
		tw = {g.mw_rem, g.mw_dv[MDIV_STEPS-1]};
		to = {g.mo_rem, g.mo_dv[MDIV_STEPS-1]};
		if (tw >= {1'b0, muw}) begin
			r.mw_rem = 16'(tw - {1'b0, muw});
			r.mw_q = {g.mw_q[MDIV_STEPS-2:0], 1'b1};
		end else begin
			r.mw_rem = tw[15:0];
			r.mw_q = {g.mw_q[MDIV_STEPS-2:0], 1'b0};
		end
		if (to >= {1'b0, muo}) begin
			r.mo_rem = 16'(to - {1'b0, muo});
			r.mo_q = {g.mo_q[MDIV_STEPS-2:0], 1'b1};
		end else begin
			r.mo_rem = to[15:0];
			r.mo_q = {g.mo_q[MDIV_STEPS-2:0], 1'b0};
		end
		r.mw_dv = {g.mw_dv[MDIV_STEPS-2:0], 1'b0};
		r.mo_dv = {g.mo_dv[MDIV_STEPS-2:0], 1'b0};
		if (frac) begin
			tf = {g.fr_rem, g.fr_n[FDIV_STEPS-1]};
			if (tf >= {1'b0, g.fr_den}) begin
				r.fr_rem = (PERM_W+17)'(tf - {1'b0, g.fr_den});
				r.fr_q = {g.fr_q[FDIV_STEPS-2:0], 1'b1};
			end else begin
				r.fr_rem = tf[PERM_W+16:0];
				r.fr_q = {g.fr_q[FDIV_STEPS-2:0], 1'b0};
			end
			r.fr_n = {g.fr_n[FDIV_STEPS-2:0], 1'b0};
		end
		return r;
	endfunction

	// The lowest numerator bit enters on the first divider step.
	function automatic logic s_tdata_lsb_w(cdiv_t c);
		logic [SAT_W-1:0] n;
		n = (c.s > {2'b0, swr_q}) ? SAT_W'(c.s - {2'b0, swr_q}) : '0;
		return n[0];
	endfunction

	function automatic logic s_tdata_lsb_o(cdiv_t c);
		logic [SAT_W-1:0] r;
		logic [SAT_W-1:0] n;
		r = SAT_W'(ONE - c.s);
		n = (r > {2'b0, sor_q}) ? SAT_W'(r - {2'b0, sor_q}) : '0;
		return n[0];
	endfunction

	assign en = !out_vld_s49 || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;
	assign den_c = SAT_W'(ONE - {2'b0, swr_q} - {2'b0, sor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swr_q <= '0;
			sor_q <= '0;
			muw_q <= 16'd256;
			muo_q <= 16'd256;
			model_q <= MODEL_COREY;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_IRR_WATER: swr_q <= cfg_data[14:0];
				REG_RES_OIL: sor_q <= cfg_data[14:0];
				REG_WATER_VISC: muw_q <= cfg_data;
				REG_OIL_VISC: muo_q <= cfg_data;
				REG_PERM_MODEL: model_q <= perm_model_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// Clamp the saturation and form both Corey numerators; negative ones become zero.
	always_comb begin
		logic [SAT_W-1:0] s_c;
		logic [SAT_W-1:0] r_c;
		logic [SAT_W-1:0] nw_c;
		logic [SAT_W-1:0] no_c;
		s_c = (s_tdata[SAT_W-1:0] > ONE) ? ONE : s_tdata[SAT_W-1:0];
		r_c = SAT_W'(ONE - s_c);
		nw_c = (s_c > {2'b0, swr_q}) ? SAT_W'(s_c - {2'b0, swr_q}) : '0;
		no_c = (r_c > {2'b0, sor_q}) ? SAT_W'(r_c - {2'b0, sor_q}) : '0;
		cinit.vld = s_tvalid;
		cinit.s = s_c;
		cinit.rw = {1'b0, nw_c[SAT_W-1:1]};
		cinit.ro = {1'b0, no_c[SAT_W-1:1]};
		cinit.qw = '0;
		cinit.qo = '0;
		// A numerator of twice the denominator or more gives Se of two or more.
		cinit.bw = {1'b0, nw_c} >= {den_c, 1'b0};
		cinit.bo = {1'b0, no_c} >= {den_c, 1'b0};
	end

	always_comb begin
		cdv_n[0] = cstep(cinit, den_c, s_tdata_lsb_w(cinit), s_tdata_lsb_o(cinit));
		for (int j = 1; j < CDIV_STEPS; j++) begin
			cdv_n[j] = cstep(cdv_s2[j-1], den_c, 1'b0, 1'b0);
		end
	end

	always_comb begin
		logic [SAT_W-1:0] sq_s;
		logic [SAT_W-1:0] sq_r;
		sq_s = cdv_s2[CDIV_STEPS-1].s;
		sq_r = SAT_W'(ONE - sq_s);
		sq_n.vld = cdv_s2[CDIV_STEPS-1].vld;
		sq_n.bw = cdv_s2[CDIV_STEPS-1].bw;
		sq_n.bo = cdv_s2[CDIV_STEPS-1].bo;
		sq_n.pw = (2*SAT_W)'(cdv_s2[CDIV_STEPS-1].qw) * (2*SAT_W)'(cdv_s2[CDIV_STEPS-1].qw);
		sq_n.po = (2*SAT_W)'(cdv_s2[CDIV_STEPS-1].qo) * (2*SAT_W)'(cdv_s2[CDIV_STEPS-1].qo);
		sq_n.ps = (2*SAT_W)'(sq_s) * (2*SAT_W)'(sq_s);
		sq_n.pr = (2*SAT_W)'(sq_r) * (2*SAT_W)'(sq_r);
	end

	always_comb begin
		logic [2*SAT_W:0] rw;
		logic [2*SAT_W:0] ro;
		logic [2*SAT_W:0] rs;
		logic [2*SAT_W:0] rr;
		logic [PERM_W:0] kw;
		logic [PERM_W:0] ko;
		logic satw;
		logic sato;
		rw = {1'b0, sq_s19.pw} + HALF;
		ro = {1'b0, sq_s19.po} + HALF;
		rs = {1'b0, sq_s19.ps} + HALF;
		rr = {1'b0, sq_s19.pr} + HALF;
		kw = rw[FRAC_BITS +: PERM_W+1];
		ko = ro[FRAC_BITS +: PERM_W+1];
		satw = sq_s19.bw || kw[PERM_W];
		sato = sq_s19.bo || ko[PERM_W];
		kr_n.vld = sq_s19.vld;
		kr_n.sat = satw || sato;
		kr_n.cw = satw ? PERM_MAX : kw[PERM_W-1:0];
		kr_n.co = sato ? PERM_MAX : ko[PERM_W-1:0];
		kr_n.bad = 1'b0;
		case (model_q)
			MODEL_LINEAR: begin
				kr_n.krw = PERM_W'(s_s19);
				kr_n.kro = PERM_W'(SAT_W'(ONE - s_s19));
			end
			MODEL_QUADRATIC: begin
				kr_n.krw = rs[FRAC_BITS +: PERM_W];
				kr_n.kro = rr[FRAC_BITS +: PERM_W];
			end
			MODEL_COREY: begin
				kr_n.krw = kr_n.cw;
				kr_n.kro = kr_n.co;
			end
			default: begin
				kr_n.krw = '0;
				kr_n.kro = '0;
				kr_n.bad = 1'b1;
			end
		endcase
	end

	always_comb begin
		pr_n.vld = kr_s20.vld;
		pr_n.sat = kr_s20.sat;
		pr_n.bad = kr_s20.bad;
		pr_n.krw = kr_s20.krw;
		pr_n.kro = kr_s20.kro;
		pr_n.fnum = (PERM_W+16)'(kr_s20.cw) * (PERM_W+16)'(muo_q);
		pr_n.fco = (PERM_W+16)'(kr_s20.co) * (PERM_W+16)'(muw_q);
	end

	always_comb begin
		logic [PERM_W+16:0] d;
		d = {1'b0, pr_s21.fnum} + {1'b0, pr_s21.fco};
		fs_n.vld = pr_s21.vld;
		fs_n.sat = pr_s21.sat;
		fs_n.bad = pr_s21.bad;
		fs_n.krw = pr_s21.krw;
		fs_n.kro = pr_s21.kro;
		fs_n.den = d;
		// Rounded quotient: add half the denominator to the scaled numerator.
		fs_n.nn = (PERM_W+33)'({pr_s21.fnum, FRAC_BITS'(0)}) + (PERM_W+33)'(d >> 1);
	end

	always_comb begin
		ginit.vld = fs_s22.vld;
		ginit.sat = fs_s22.sat;
		ginit.bad = fs_s22.bad;
		ginit.fzero = (fs_s22.den == '0);
		ginit.krw = fs_s22.krw;
		ginit.kro = fs_s22.kro;
		ginit.mw_rem = '0;
		ginit.mw_dv = {fs_s22.krw, 8'd0};
		ginit.mw_q = '0;
		ginit.mo_rem = '0;
		ginit.mo_dv = {fs_s22.kro, 8'd0};
		ginit.mo_q = '0;
		ginit.fr_rem = {1'b0, fs_s22.nn[PERM_W+32:FDIV_STEPS]};
		ginit.fr_n = fs_s22.nn[FDIV_STEPS-1:0];
		ginit.fr_q = '0;
		ginit.fr_den = fs_s22.den;
		gdv_n[0] = gstep(ginit, muw_q, muo_q, 1'b1);
		for (int j = 1; j < MDIV_STEPS; j++) begin
			gdv_n[j] = gstep(gdv_s23[j-1], muw_q, muo_q, j < FDIV_STEPS);
		end
	end

	always_comb begin
		gdiv_t g;
		logic [MDIV_STEPS:0] mob;
		logic musz;
		logic msat;
		logic fz;
		logic [MOB_W-1:0] mob_o;
		logic [SAT_W-1:0] fw;
		logic [SAT_W-1:0] fo;
		g = gdv_s23[MDIV_STEPS-1];
		mob = {1'b0, g.mw_q} + {1'b0, g.mo_q};
		musz = (muw_q == '0) || (muo_q == '0);
		msat = mob > (MDIV_STEPS+1)'(MOB_MAX);
		if (g.bad || musz) begin
			mob_o = '0;
		end else begin
			mob_o = msat ? MOB_MAX : mob[MOB_W-1:0];
		end
		fz = musz || g.fzero;
		if (fz) begin
			fw = '0;
			fo = '0;
		end else begin
			fw = (g.fr_q > ONE) ? ONE : g.fr_q;
			fo = SAT_W'(ONE - fw);
		end
		out_data_n = {2'b00, fo, fw, mob_o, g.kro, g.krw};
		if (g.bad) begin
			out_st_n = ST_UNKNOWN_MODEL;
		end else if (fz) begin
			out_st_n = ST_ZERO_DEN;
		end else if (g.sat || msat) begin
			out_st_n = ST_SATURATED;
		end else begin
			out_st_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CDIV_STEPS; j++) begin
				cdv_s2[j].vld <= 1'b0;
			end
			sq_s19.vld <= 1'b0;
			kr_s20.vld <= 1'b0;
			pr_s21.vld <= 1'b0;
			fs_s22.vld <= 1'b0;
			for (int j = 0; j < MDIV_STEPS; j++) begin
				gdv_s23[j].vld <= 1'b0;
			end
			out_vld_s49 <= 1'b0;
		end else if (en) begin
			cdv_s2 <= cdv_n;
			sq_s19 <= sq_n;
			s_s19 <= cdv_s2[CDIV_STEPS-1].s;
			kr_s20 <= kr_n;
			pr_s21 <= pr_n;
			fs_s22 <= fs_n;
			gdv_s23 <= gdv_n;
			out_vld_s49 <= gdv_s23[MDIV_STEPS-1].vld;
			out_data_s49 <= out_data_n;
			out_st_s49 <= out_st_n;
		end
	end

	assign m_tvalid = out_vld_s49;
	assign m_tdata = out_data_s49;
	assign m_tuser = out_st_s49;

	a_frac_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_OK) |->
		({1'b0, m_tdata[76:60]} + {1'b0, m_tdata[93:77]}) == {1'b0, ONE})
		else $error("fractions of a clean item do not sum to one");

	a_bad_model_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_UNKNOWN_MODEL) |-> m_tdata[59:0] == '0)
		else $error("unknown model item carries permeability or mobility");

	a_zero_den_frac: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ZERO_DEN) |-> m_tdata[93:60] == '0)
		else $error("zero denominator item carries fractional flow");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> cdv_s2[0].vld)
		else $error("accepted item did not enter the first stage");

endmodule
